@@ rtl/core/resd_pkg.sv @@
// ----------------------------------------------------------------------------
// resd_pkg
// Shared types and widths for the descending record sorter.
// ----------------------------------------------------------------------------
package resd_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 8;

  // One stored record, as held in a single memory word.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

@@ rtl/core/resd_ram.sv @@
// ----------------------------------------------------------------------------
// resd_ram
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module resd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/resd_ctrl.sv @@
// ----------------------------------------------------------------------------
// resd_ctrl
// Sequencer for load, in-memory exchange sort and read-out of the records.
// ----------------------------------------------------------------------------
module resd_ctrl
  import resd_pkg::*;
#(
  parameter int MAX_RECORDS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [KEY_W-1:0]               in_sort_key,
  input  logic [TAG_W-1:0]               in_record_tag,
  input  logic                           in_last_record,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [KEY_W-1:0]               out_key,
  output logic [TAG_W-1:0]               out_tag,
  output logic                           out_last,
  output logic                           out_overflow,
  output logic                           mem_we,
  output logic [$clog2(MAX_RECORDS)-1:0] mem_waddr,
  output rec_t                           mem_wdata,
  output logic [$clog2(MAX_RECORDS)-1:0] mem_raddr,
  input  rec_t                           mem_rdata
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_HEAD,
    ST_SCAN,
    ST_WB,
    ST_FETCH,
    ST_SHOW
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    cnt_r;
  logic             drop_r;
  logic [AW-1:0]    i_r;
  logic [AW-1:0]    j_r;
  rec_t             best_r;
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [TAG_W-1:0] out_tag_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic             in_acc;
  logic             room;
  logic [AW-1:0]    last_idx;
  logic             swap;
  logic             sort_done;
  logic             fetch_fwd;
  rec_t             fetch_rec;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign room      = (cnt_r < CW'(MAX_RECORDS));
  assign last_idx  = AW'(cnt_r - CW'(1));
  assign swap      = (best_r.key < mem_rdata.key);
  assign sort_done = ((i_r + AW'(1)) == last_idx);

  // A set of two records writes position 0 back in the same cycle that
  // position 0 is read for the first output, so that read returns the old
  // word. The held record is the one just written and is taken instead.
  assign fetch_fwd = (cnt_r == CW'(2)) && (i_r == '0);
  assign fetch_rec = fetch_fwd ? best_r : mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = best_r;
    mem_raddr = '0;
    unique case (state_r)
      ST_LOAD: begin
        mem_we         = in_acc && room;
        mem_waddr      = cnt_r[AW-1:0];
        mem_wdata.key  = in_sort_key;
        mem_wdata.tag  = in_record_tag;
      end
      ST_START: begin
        mem_raddr = '0;
      end
      ST_HEAD: begin
        mem_raddr = i_r + AW'(1);
      end
      ST_SCAN: begin
        mem_we    = swap;
        mem_waddr = j_r;
        mem_raddr = j_r + AW'(1);
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_raddr = sort_done ? '0 : i_r + AW'(1);
      end
      ST_FETCH: begin
        mem_raddr = i_r;
      end
      ST_SHOW: begin
        mem_raddr = i_r + AW'(1);
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              drop_r <= 1'b1;
            end
            if (in_last_record) begin
              state_r <= ST_START;
            end
          end
        end
        ST_START: begin
          i_r     <= '0;
          state_r <= (cnt_r >= CW'(2)) ? ST_HEAD : ST_FETCH;
        end
        ST_HEAD: begin
          best_r  <= mem_rdata;
          j_r     <= i_r + AW'(1);
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (swap) begin
            best_r <= mem_rdata;
          end
          if (j_r == last_idx) begin
            state_r <= ST_WB;
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        ST_WB: begin
          if (sort_done) begin
            i_r     <= '0;
            state_r <= ST_FETCH;
          end else begin
            i_r     <= i_r + AW'(1);
            state_r <= ST_HEAD;
          end
        end
        ST_FETCH: begin
          out_valid_r <= 1'b1;
          out_key_r   <= fetch_rec.key;
          out_tag_r   <= fetch_rec.tag;
          out_last_r  <= (i_r == last_idx);
          out_ovf_r   <= drop_r;
          state_r     <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              cnt_r   <= '0;
              drop_r  <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              i_r     <= i_r + AW'(1);
              state_r <= ST_FETCH;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key      = out_key_r;
  assign out_tag      = out_tag_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

@@ rtl/core/record_exchange_sort_desc_core.sv @@
// ----------------------------------------------------------------------------
// record_exchange_sort_desc_core
// Collects keyed records and returns them in descending key order.
// ----------------------------------------------------------------------------
// Records (a 16-bit unsigned key and an 8-bit tag) are taken one item per
// cycle until an item with in_last_record set arrives; up to MAX_RECORDS are
// kept, and any further records of the set are discarded and reported by
// out_overflow on every result of that set. After the last item the block
// stops taking input and sorts the held set in place in a single record
// memory, following the classic exchange scheme: each position i is held in
// a register while positions i+1 onwards are read one per cycle, and
// whenever the held key is smaller than the key read, the two swap. Records
// with equal keys therefore end up in exactly the order that scheme gives.
// The sort works through the one read and one write port of the memory.
// The records are then delivered in order, each fetched from the memory
// into the output register and held there until the receiver takes it;
// only then is the next one fetched. out_last marks the final one, and
// once that item is taken the block is ready for the next set.
// ----------------------------------------------------------------------------
module record_exchange_sort_desc_core
  import resd_pkg::*;
#(
  parameter int MAX_RECORDS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] in_sort_key,
  input  logic [TAG_W-1:0] in_record_tag,
  input  logic             in_last_record,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_key,
  output logic [TAG_W-1:0] out_tag,
  output logic             out_last,
  output logic             out_overflow
);

  localparam int AW = $clog2(MAX_RECORDS);

  // Memory port signals between the sequencer and the record store.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_rdata;

  // The sequencer owns the load count, the overflow flag, the sort indices
  // and the output register.
  resd_ctrl #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sort_key   (in_sort_key),
    .in_record_tag (in_record_tag),
    .in_last_record(in_last_record),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key       (out_key),
    .out_tag       (out_tag),
    .out_last      (out_last),
    .out_overflow  (out_overflow),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  // Record store: key and tag side by side in one word, so that a swap
  // moves both with a single write.
  resd_ram #(
    .W(REC_W),
    .D(MAX_RECORDS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

@@ test/resd_order_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resd_order_checker
// Watches both channels of the record sorter and checks every result.
// ----------------------------------------------------------------------------
// Each accepted record is added to a private copy of the current set. On the
// record marked last, the copy is put through the same exchange procedure the
// block uses, and the sorted records are queued as the results due. Every
// accepted result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module resd_order_checker
  import resd_pkg::*;
#(
  parameter int MAX_RECORDS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [KEY_W-1:0] in_sort_key,
  input  logic [TAG_W-1:0] in_record_tag,
  input  logic             in_last_record,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [KEY_W-1:0] out_key,
  input  logic [TAG_W-1:0] out_tag,
  input  logic             out_last,
  input  logic             out_overflow,
  output int               mismatch_count,
  output int               results_due,
  output int               results_checked,
  output int               overflow_sets
);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             overflow;
  } sorted_rec_t;

  rec_t        set_recs [MAX_RECORDS];
  int          set_count;
  logic        set_spilled;
  sorted_rec_t sorted_due [$];

  initial begin
    mismatch_count  = 0;
    results_due     = 0;
    results_checked = 0;
    overflow_sets   = 0;
    set_count       = 0;
    set_spilled     = 1'b0;
  end

  // Sort the held set exactly as the exchange procedure does and queue it.
  task automatic sort_and_queue_set();
    rec_t        work [MAX_RECORDS];
    rec_t        held;
    sorted_rec_t due;
    int          i;
    int          j;
    for (i = 0; i < set_count; i++) work[i] = set_recs[i];
    for (i = 0; i + 1 < set_count; i++) begin
      for (j = i + 1; j < set_count; j++) begin
        if (work[i].key < work[j].key) begin
          held    = work[i];
          work[i] = work[j];
          work[j] = held;
        end
      end
    end
    for (i = 0; i < set_count; i++) begin
      due.key      = work[i].key;
      due.tag      = work[i].tag;
      due.last     = (i == set_count - 1);
      due.overflow = set_spilled;
      sorted_due.push_back(due);
    end
    if (set_spilled) overflow_sets++;
    set_count   = 0;
    set_spilled = 1'b0;
  endtask

  always @(posedge clk) begin
    sorted_rec_t want;
    if (!rst_n) begin
      set_count   = 0;
      set_spilled = 1'b0;
      sorted_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (set_count < MAX_RECORDS) begin
          set_recs[set_count].key = in_sort_key;
          set_recs[set_count].tag = in_record_tag;
          set_count++;
        end else begin
          set_spilled = 1'b1;
        end
        if (in_last_record) sort_and_queue_set();
      end
      if (out_valid && !out_stall) begin
        if (sorted_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result key %h tag %h last %b overflow %b",
                     $realtime, out_key, out_tag, out_last, out_overflow);
        end else begin
          want = sorted_due.pop_front();
          if (want.key !== out_key || want.tag !== out_tag ||
              want.last !== out_last || want.overflow !== out_overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("%0t: result %0d expected key %h tag %h last %b overflow %b, ",
                     $realtime, results_checked, want.key, want.tag, want.last,
                     want.overflow);
              $display("got key %h tag %h last %b overflow %b",
                       out_key, out_tag, out_last, out_overflow);
            end
          end
        end
        results_checked++;
      end
    end
    results_due = sorted_due.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the descending record sorter.
// ----------------------------------------------------------------------------
// Feeds sets of keyed records into the sorter: first hand-picked sets for the
// key extremes and equal keys, then an overfull store, then random sets of
// mostly small size. The checker beside the block predicts and compares every
// sorted result; this module only drives the channels and reports the outcome.
// ----------------------------------------------------------------------------
module testbench;
  import resd_pkg::*;

  localparam int MAX_RECORDS = 64;
  // Number of cycles for which the receiver refuses results in one go.
  localparam int LONG_HOLD   = 400;

  // How the keys of a random set are chosen.
  typedef enum int {
    MIX_WIDE,   // any 16-bit value
    MIX_TIES,   // a handful of values, so equal keys are common
    MIX_EDGES   // extremes and values around the sign bit
  } key_mix_e;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [KEY_W-1:0] in_sort_key;
  logic [TAG_W-1:0] in_record_tag;
  logic             in_last_record;
  logic             out_valid;
  logic             out_stall;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             out_last;
  logic             out_overflow;

  int mismatch_count;
  int results_due;
  int results_checked;
  int overflow_sets;

  // Idling percentages for each side; the stimulus process changes them by phase.
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  // The stimulus bumps this to ask the receiver for one long hold-off.
  int hold_requests = 0;

  int records_sent = 0;
  int sets_sent    = 0;

  always #2 clk = ~clk;

  record_exchange_sort_desc_core #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sort_key   (in_sort_key),
    .in_record_tag (in_record_tag),
    .in_last_record(in_last_record),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key       (out_key),
    .out_tag       (out_tag),
    .out_last      (out_last),
    .out_overflow  (out_overflow)
  );

  resd_order_checker #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sort_key    (in_sort_key),
    .in_record_tag  (in_record_tag),
    .in_last_record (in_last_record),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key        (out_key),
    .out_tag        (out_tag),
    .out_last       (out_last),
    .out_overflow   (out_overflow),
    .mismatch_count (mismatch_count),
    .results_due    (results_due),
    .results_checked(results_checked),
    .overflow_sets  (overflow_sets)
  );

  // Receiver side. It stalls at random according to take_idle_pct, except
  // during a requested hold-off, which it counts down here in whole cycles.
  // All changes are made on the falling edge, away from the sampling edge.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < take_idle_pct);
      end
    end
  end

  // Offers one record and returns once it has been accepted. It is entered
  // just after a falling edge and leaves just after one, so each signal gets
  // at most one assignment per falling edge whether the sender idles or not.
  task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                             input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sort_key    <= key;
    in_record_tag  <= tag;
    in_last_record <= last;
    // The item is taken at the first rising edge that sees stall low.
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    records_sent++;
    if (last) sets_sent++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input key_mix_e mix);
    logic [KEY_W-1:0] key;
    case (mix)
      MIX_TIES: begin
        key = KEY_W'($urandom_range(3)) << 14;
      end
      MIX_EDGES: begin
        case ($urandom_range(5))
          0: key = 16'h0000;
          1: key = 16'hFFFF;
          2: key = 16'h8000;
          3: key = 16'h7FFF;
          4: key = 16'h0001;
          default: key = 16'hFFFE;
        endcase
      end
      default: begin
        key = KEY_W'($urandom());
      end
    endcase
    return key;
  endfunction

  // One whole set of the given size with random tags; the final record is
  // marked last. Sizes beyond MAX_RECORDS exercise the dropping of records.
  task automatic send_random_set(input int size, input key_mix_e mix);
    int r;
    for (r = 0; r < size; r++)
      send_record(pick_key(mix), TAG_W'($urandom()), r == size - 1);
  endtask

  task automatic wait_for_results();
    while (results_due != 0) @(negedge clk);
  endtask

  // Main stimulus.
  initial begin
    int random_base;
    int size;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_sort_key    <= '0;
    in_record_tag  <= '0;
    in_last_record <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: the sender idles now and then, the receiver most of the time.
    send_idle_pct = 35;
    take_idle_pct = 75;

    // A set of a single record: it is both first and last.
    send_record(16'hFFFF, 8'hFF, 1'b1);
    // Two records in ascending order, so the sort must swap them.
    send_record(16'h0000, 8'h00, 1'b0);
    send_record(16'hFFFF, 8'h01, 1'b1);
    // Equal keys interleaved: the tags show the order the exchange scheme
    // leaves among records with the same key.
    send_record(16'h0005, 8'h11, 1'b0);
    send_record(16'h0009, 8'h22, 1'b0);
    send_record(16'h0005, 8'h33, 1'b0);
    send_record(16'h0009, 8'h44, 1'b0);
    send_record(16'h0005, 8'h55, 1'b1);
    // Keys at the extremes and either side of the top bit, which an unsigned
    // compare must not treat as a sign.
    send_record(16'h7FFF, 8'hAA, 1'b0);
    send_record(16'h0000, 8'h55, 1'b0);
    send_record(16'h8000, 8'h80, 1'b0);
    send_record(16'hFFFF, 8'h7F, 1'b0);
    send_record(16'h0001, 8'h01, 1'b1);
    wait_for_results();

    // Phase two: the roles swap, the receiver idles less than the sender.
    send_idle_pct = 75;
    take_idle_pct = 35;

    // Two records past capacity: the store fills completely, the first
    // extra record is dropped, and so is the last one, yet the held ones
    // are still sorted and delivered with overflow set.
    send_random_set(MAX_RECORDS + 2, MIX_EDGES);
    wait_for_results();

    // Random sets, mostly small, with the occasional medium-sized one.
    random_base = records_sent;
    while (records_sent - random_base < 20) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      send_random_set(size, key_mix_e'($urandom_range(2)));
    end
    wait_for_results();

    // Phase three: neither side idles. The receiver first holds off for a
    // long stretch while two sets are offered back to back, so the block
    // has to hold the second set off at its input until results drain.
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_requests++;
    send_random_set(8, MIX_TIES);
    send_random_set(6, MIX_WIDE);
    while (records_sent - random_base < 40) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      send_random_set(size, key_mix_e'($urandom_range(2)));
    end
    in_valid <= 1'b0;

    wait_for_results();
    // A few more cycles to catch any result the block sends unasked.
    repeat (50) @(negedge clk);

    $display("Run covered %0d records in %0d sets, %0d of them with dropped records.",
             records_sent, sets_sent, overflow_sets);
    $display("%0d sorted results were compared, %0d of them differed.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Backstop in case the block hangs: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still due.", results_due);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/resd_pkg.sv
rtl/core/resd_ram.sv
rtl/core/resd_ctrl.sv
rtl/core/record_exchange_sort_desc_core.sv
test/resd_order_checker.sv
test/testbench.sv
